// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers for the vertex transform block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/vtbb_pkg.sv
// ---------------------------------------------------------------------------
// vtbb_pkg
// Types, register map, micro-op encoding and the micro-op table.
// ---------------------------------------------------------------------------
package vtbb_pkg;

  // Default datapath parameters
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int QUAT_FRAC_BITS_DEF  = 14;

  // Packed register field width
  localparam int PACK_W = 16;

  // Configuration port
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUAT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANS = 2'd2;

  localparam logic [47:0] SCALE_RST = 48'h0100_0100_0100;
  localparam logic [63:0] QUAT_RST  = 64'h4000_0000_0000_0000;
  localparam logic [47:0] TRANS_RST = 48'h0;

  // Coefficient select (register fields)
  localparam logic [2:0] COEF_SX = 3'd0;
  localparam logic [2:0] COEF_SY = 3'd1;
  localparam logic [2:0] COEF_SZ = 3'd2;
  localparam logic [2:0] COEF_W  = 3'd3;
  localparam logic [2:0] COEF_QX = 3'd4;
  localparam logic [2:0] COEF_QY = 3'd5;
  localparam logic [2:0] COEF_QZ = 3'd6;

  // Operand select (vertex, scaled vertex, half-turn vector)
  localparam logic [3:0] OPD_VX = 4'd0;
  localparam logic [3:0] OPD_VY = 4'd1;
  localparam logic [3:0] OPD_VZ = 4'd2;
  localparam logic [3:0] OPD_SX = 4'd3;
  localparam logic [3:0] OPD_SY = 4'd4;
  localparam logic [3:0] OPD_SZ = 4'd5;
  localparam logic [3:0] OPD_TX = 4'd6;
  localparam logic [3:0] OPD_TY = 4'd7;
  localparam logic [3:0] OPD_TZ = 4'd8;

  // Destination of a finished accumulation
  localparam logic [1:0] DST_S = 2'd0;
  localparam logic [1:0] DST_T = 2'd1;
  localparam logic [1:0] DST_O = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Sequencer timing
  localparam int NUM_OPS    = 18;
  localparam int RUN_CYCLES = NUM_OPS + 2;   // multiplier + accumulate + box drain
  localparam int OP_IDX_W   = $clog2(NUM_OPS);
  localparam int CNT_W      = $clog2(RUN_CYCLES);

  typedef struct packed {
    logic [2:0] coef;
    logic [3:0] opd;
    logic       first;   // start from the preload value
    logic       neg;     // subtract the product
    logic       last;    // write the result to its destination
    logic [1:0] dst;
    logic [1:0] axis;
  } uop_t;

  typedef struct packed {
    logic valid;
    uop_t uop;
  } issue_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] axis;
  } fin_t;

  // Ordered so every operand is written before it is read.
  function automatic uop_t uop_rom(input logic [OP_IDX_W-1:0] idx);
    uop_t r;
    case (idx)
      // scaled vertex
      5'd0:  r = '{COEF_SX, OPD_VX, 1'b1, 1'b0, 1'b1, DST_S, AXIS_X};
      5'd1:  r = '{COEF_SY, OPD_VY, 1'b1, 1'b0, 1'b1, DST_S, AXIS_Y};
      5'd2:  r = '{COEF_SZ, OPD_VZ, 1'b1, 1'b0, 1'b1, DST_S, AXIS_Z};
      // t = 2 (q x s), rounded
      5'd3:  r = '{COEF_QY, OPD_SX, 1'b1, 1'b1, 1'b0, DST_T, AXIS_Z};
      5'd4:  r = '{COEF_QX, OPD_SY, 1'b0, 1'b0, 1'b1, DST_T, AXIS_Z};
      5'd5:  r = '{COEF_QZ, OPD_SX, 1'b1, 1'b0, 1'b0, DST_T, AXIS_Y};
      5'd6:  r = '{COEF_QX, OPD_SZ, 1'b0, 1'b1, 1'b1, DST_T, AXIS_Y};
      5'd7:  r = '{COEF_QY, OPD_SZ, 1'b1, 1'b0, 1'b0, DST_T, AXIS_X};
      5'd8:  r = '{COEF_QZ, OPD_SY, 1'b0, 1'b1, 1'b1, DST_T, AXIS_X};
      // out = s + trans + w t + q x t
      5'd9:  r = '{COEF_W,  OPD_TZ, 1'b1, 1'b0, 1'b0, DST_O, AXIS_Z};
      5'd10: r = '{COEF_QX, OPD_TY, 1'b0, 1'b0, 1'b0, DST_O, AXIS_Z};
      5'd11: r = '{COEF_QY, OPD_TX, 1'b0, 1'b1, 1'b1, DST_O, AXIS_Z};
      5'd12: r = '{COEF_W,  OPD_TY, 1'b1, 1'b0, 1'b0, DST_O, AXIS_Y};
      5'd13: r = '{COEF_QZ, OPD_TX, 1'b0, 1'b0, 1'b0, DST_O, AXIS_Y};
      5'd14: r = '{COEF_QX, OPD_TZ, 1'b0, 1'b1, 1'b1, DST_O, AXIS_Y};
      5'd15: r = '{COEF_W,  OPD_TX, 1'b1, 1'b0, 1'b0, DST_O, AXIS_X};
      5'd16: r = '{COEF_QY, OPD_TZ, 1'b0, 1'b0, 1'b0, DST_O, AXIS_X};
      5'd17: r = '{COEF_QZ, OPD_TY, 1'b0, 1'b1, 1'b1, DST_O, AXIS_X};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: src/vtbb_seq.sv
// ---------------------------------------------------------------------------
// vtbb_seq
// Sequencer: walks the micro-op table once per vertex and hands off results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vtbb_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_free,
  output logic              in_ready,
  output vtbb_pkg::issue_t  issue,
  output logic              commit
);
  import vtbb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign in_ready    = (state == ST_IDLE);
  assign commit      = (state == ST_HOLD) && out_free;
  assign issue.valid = (state == ST_RUN) && (cnt < CNT_W'(NUM_OPS));
  assign issue.uop   = uop_rom(cnt[OP_IDX_W-1:0]);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
          cnt_next   = '0;
        end
      end
      ST_RUN: begin
        if (cnt == CNT_W'(RUN_CYCLES - 1)) begin
          state_next = ST_HOLD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `ASSERT_IMP(a_no_issue_when_ready, clk, rst, issue.valid, !in_ready, "issue while ready")
  `ASSERT_NXT(a_accept_starts_seq, clk, rst, in_valid && in_ready, issue.valid && issue.uop.first, "accepted beat did not start the sequence")

endmodule

// File: src/vtbb_mac.sv
// ---------------------------------------------------------------------------
// vtbb_mac
// Shared multiply-accumulate unit with operand store and output saturation.
// ---------------------------------------------------------------------------
module vtbb_mac #(
  parameter int COORD_WIDTH     = vtbb_pkg::COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = vtbb_pkg::COORD_FRAC_BITS_DEF,
  parameter int QUAT_FRAC_BITS  = vtbb_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [COORD_WIDTH-1:0] v_x,
  input  logic signed [COORD_WIDTH-1:0] v_y,
  input  logic signed [COORD_WIDTH-1:0] v_z,
  input  logic [47:0]                   scale_xyz,
  input  logic [63:0]                   rotation_quat,
  input  logic [47:0]                   translation_xyz,
  input  vtbb_pkg::issue_t              issue,
  output vtbb_pkg::fin_t                fin,
  output logic signed [COORD_WIDTH-1:0] fin_value
);
  import vtbb_pkg::*;

  // Scaled vertex, half-turn vector, operand and accumulator widths
  localparam int SW   = COORD_WIDTH + 17 - COORD_FRAC_BITS;
  localparam int TW   = SW + 19 - QUAT_FRAC_BITS;
  localparam int OPW0 = (SW > COORD_WIDTH) ? SW : COORD_WIDTH;
  localparam int OPW  = (TW > OPW0) ? TW : OPW0;
  localparam int PW   = PACK_W + OPW;
  localparam int STW  = ((SW > PACK_W) ? SW : PACK_W) + 1;
  localparam int AOW  = ((TW + 17 > STW + QUAT_FRAC_BITS + 1) ?
                         TW + 17 : STW + QUAT_FRAC_BITS + 1) + 1;
  localparam int ACW0 = (COORD_WIDTH + 18 > SW + 19) ? COORD_WIDTH + 18 : SW + 19;
  localparam int ACCW = (AOW > ACW0) ? AOW : ACW0;
  localparam int RW   = ACCW - QUAT_FRAC_BITS;

  // Rounding offsets (add half, then floor)
  localparam logic signed [ACCW-1:0] HALF_F = (COORD_FRAC_BITS == 0) ? '0 :
                                              ACCW'(1) << (COORD_FRAC_BITS - 1);
  localparam logic signed [ACCW-1:0] HALF_T = ACCW'(1) << (QUAT_FRAC_BITS - 2);
  localparam logic signed [ACCW-1:0] HALF_Q = ACCW'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [PACK_W-1:0] coef;
  logic signed [OPW-1:0]    opnd;
  logic signed [PW-1:0]     prod;
  uop_t                     uop_d;
  logic                     valid_d;

  logic signed [SW-1:0] s_x, s_y, s_z, s_sel;
  logic signed [TW-1:0] t_x, t_y, t_z;
  logic signed [PACK_W-1:0] tr_sel;
  logic signed [STW-1:0]    st_sum;

  logic signed [ACCW-1:0] acc, pre, base, addend, sum;
  logic signed [RW-1:0]   r;
  logic [RW-COORD_WIDTH:0] r_hi;
  logic signed [COORD_WIDTH-1:0] o_sat;

  // Issue stage: operand select and the one multiplier
  always_comb begin
    case (issue.uop.coef)
      COEF_SX: coef = scale_xyz[47:32];
      COEF_SY: coef = scale_xyz[31:16];
      COEF_SZ: coef = scale_xyz[15:0];
      COEF_W:  coef = rotation_quat[63:48];
      COEF_QX: coef = rotation_quat[47:32];
      COEF_QY: coef = rotation_quat[31:16];
      COEF_QZ: coef = rotation_quat[15:0];
      default: coef = '0;
    endcase
    case (issue.uop.opd)
      OPD_VX:  opnd = OPW'(v_x);
      OPD_VY:  opnd = OPW'(v_y);
      OPD_VZ:  opnd = OPW'(v_z);
      OPD_SX:  opnd = OPW'(s_x);
      OPD_SY:  opnd = OPW'(s_y);
      OPD_SZ:  opnd = OPW'(s_z);
      OPD_TX:  opnd = OPW'(t_x);
      OPD_TY:  opnd = OPW'(t_y);
      OPD_TZ:  opnd = OPW'(t_z);
      default: opnd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod  <= PW'(coef) * PW'(opnd);
    uop_d <= issue.uop;
  end

  // Accumulate stage. The output preload folds s + translation and the
  // rounding half into the start value, so finishing is a shift and a clamp.
  always_comb begin
    case (uop_d.axis)
      AXIS_X:  begin s_sel = s_x; tr_sel = translation_xyz[47:32]; end
      AXIS_Y:  begin s_sel = s_y; tr_sel = translation_xyz[31:16]; end
      default: begin s_sel = s_z; tr_sel = translation_xyz[15:0];  end
    endcase
    st_sum = STW'(s_sel) + STW'(tr_sel);
    case (uop_d.dst)
      DST_S:   pre = HALF_F;
      DST_T:   pre = HALF_T;
      DST_O:   pre = (ACCW'(st_sum) <<< QUAT_FRAC_BITS) | HALF_Q;
      default: pre = '0;
    endcase
    base   = uop_d.first ? pre : acc;
    addend = uop_d.neg ? -(ACCW'(prod)) : ACCW'(prod);
    sum    = base + addend;

    r    = sum[ACCW-1:QUAT_FRAC_BITS];
    r_hi = r[RW-1:COORD_WIDTH-1];
    if ((&r_hi) || !(|r_hi)) begin
      o_sat = r[COORD_WIDTH-1:0];
    end else begin
      o_sat = r[RW-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_d) begin
      acc <= sum;
      if (uop_d.last) begin
        case (uop_d.dst)
          DST_S: begin
            case (uop_d.axis)
              AXIS_X:  s_x <= sum[COORD_FRAC_BITS +: SW];
              AXIS_Y:  s_y <= sum[COORD_FRAC_BITS +: SW];
              default: s_z <= sum[COORD_FRAC_BITS +: SW];
            endcase
          end
          DST_T: begin
            case (uop_d.axis)
              AXIS_X:  t_x <= sum[(QUAT_FRAC_BITS-1) +: TW];
              AXIS_Y:  t_y <= sum[(QUAT_FRAC_BITS-1) +: TW];
              default: t_z <= sum[(QUAT_FRAC_BITS-1) +: TW];
            endcase
          end
          default: fin_value <= o_sat;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d   <= 1'b0;
      fin.valid <= 1'b0;
      fin.axis  <= AXIS_X;
    end else begin
      valid_d   <= issue.valid;
      fin.valid <= valid_d && uop_d.last && (uop_d.dst == DST_O);
      fin.axis  <= uop_d.axis;
    end
  end

endmodule

// File: src/vtbb_box.sv
// ---------------------------------------------------------------------------
// vtbb_box
// Transformed-vertex store and running axis-aligned bounding box.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vtbb_box #(
  parameter int COORD_WIDTH = vtbb_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vtbb_pkg::fin_t                fin,
  input  logic signed [COORD_WIDTH-1:0] fin_value,
  input  logic                          commit,
  input  logic                          commit_final,
  output logic signed [COORD_WIDTH-1:0] vtx_x,
  output logic signed [COORD_WIDTH-1:0] vtx_y,
  output logic signed [COORD_WIDTH-1:0] vtx_z,
  output logic signed [COORD_WIDTH-1:0] run_min_x,
  output logic signed [COORD_WIDTH-1:0] run_min_y,
  output logic signed [COORD_WIDTH-1:0] run_min_z,
  output logic signed [COORD_WIDTH-1:0] run_max_x,
  output logic signed [COORD_WIDTH-1:0] run_max_y,
  output logic signed [COORD_WIDTH-1:0] run_max_z
);
  import vtbb_pkg::*;

  logic box_empty;

  // Box stays empty until the vertex in flight commits, so all three axes
  // of the first vertex seed min and max.
  always_ff @(posedge clk) begin
    if (fin.valid) begin
      case (fin.axis)
        AXIS_X: begin
          vtx_x <= fin_value;
          if (box_empty || fin_value < run_min_x) run_min_x <= fin_value;
          if (box_empty || fin_value > run_max_x) run_max_x <= fin_value;
        end
        AXIS_Y: begin
          vtx_y <= fin_value;
          if (box_empty || fin_value < run_min_y) run_min_y <= fin_value;
          if (box_empty || fin_value > run_max_y) run_max_y <= fin_value;
        end
        default: begin
          vtx_z <= fin_value;
          if (box_empty || fin_value < run_min_z) run_min_z <= fin_value;
          if (box_empty || fin_value > run_max_z) run_max_z <= fin_value;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_empty <= 1'b1;
    end else if (commit) begin
      box_empty <= commit_final;
    end
  end

  `ASSERT_IMP(a_box_ordered, clk, rst, !box_empty, (run_min_x <= run_max_x) && (run_min_y <= run_max_y) && (run_min_z <= run_max_z), "box min above max")

endmodule

// File: src/vertex_transform_bounding_box.sv
// ---------------------------------------------------------------------------
// vertex_transform_bounding_box
// Scales, quaternion-rotates and translates Q8.8 vertices on one shared
// multiplier and keeps a running axis-aligned bounding box per mesh.
// ---------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_ready  | vert_x/y/z, final_vertex
//  out      | out_valid/ out_ready | out_x/y/z, box_min/max_x/y/z, box_done
//  cfg      | cfg_we (no wait)     | cfg_index, cfg_data
//
//  Per vertex, when the output is taken promptly: an accept state, 18 passes
//  through the shared 16 x N multiplier, a drain of the accumulator and box
//  update, and a hand-off into the output register. The shared multiplier
//  limits throughput; a new beat is accepted only after the hand-off.
//  The next beat is accepted while the previous result still waits; a new
//  result stalls in hand-off until the output register is free.
//  Synchronous active-high reset clears control state, the box, and restores
//  scale 1.0, identity rotation and zero translation.
//
//  Datapath per vertex:
//    s   = round(v * scale)                      (3 multiplies)
//    t   = round(2 (q x s))                      (6 multiplies)
//    out = sat(s + trans + round(w t + q x t))   (9 multiplies)
//  Rounding is add-half-then-floor; the half and the s + trans term are
//  preloaded into the accumulator at the start of each group.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_transform_bounding_box #(
  parameter int COORD_WIDTH     = vtbb_pkg::COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = vtbb_pkg::COORD_FRAC_BITS_DEF,
  parameter int QUAT_FRAC_BITS  = vtbb_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [vtbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vtbb_pkg::CFG_DATA_W-1:0]     cfg_data,
  // vertex in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       vert_x,
  input  logic signed [COORD_WIDTH-1:0]       vert_y,
  input  logic signed [COORD_WIDTH-1:0]       vert_z,
  input  logic                                final_vertex,
  // result out
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       out_x,
  output logic signed [COORD_WIDTH-1:0]       out_y,
  output logic signed [COORD_WIDTH-1:0]       out_z,
  output logic signed [COORD_WIDTH-1:0]       box_min_x,
  output logic signed [COORD_WIDTH-1:0]       box_min_y,
  output logic signed [COORD_WIDTH-1:0]       box_min_z,
  output logic signed [COORD_WIDTH-1:0]       box_max_x,
  output logic signed [COORD_WIDTH-1:0]       box_max_y,
  output logic signed [COORD_WIDTH-1:0]       box_max_z,
  output logic                                box_done
);
  import vtbb_pkg::*;

  // Configuration registers
  logic [47:0] scale_xyz;
  logic [63:0] rotation_quat;
  logic [47:0] translation_xyz;

  // Latched input beat
  logic signed [COORD_WIDTH-1:0] v_x, v_y, v_z;
  logic                          v_final;

  issue_t issue;
  fin_t   fin;
  logic signed [COORD_WIDTH-1:0] fin_value;
  logic   commit;
  logic   out_free;

  logic signed [COORD_WIDTH-1:0] vtx_x, vtx_y, vtx_z;
  logic signed [COORD_WIDTH-1:0] run_min_x, run_min_y, run_min_z;
  logic signed [COORD_WIDTH-1:0] run_max_x, run_max_y, run_max_z;

  assign out_free = !out_valid || out_ready;

  // Writes to an unmapped index fall through and are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_xyz       <= SCALE_RST;
      rotation_quat   <= QUAT_RST;
      translation_xyz <= TRANS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE: scale_xyz       <= cfg_data[47:0];
        REG_QUAT:  rotation_quat   <= cfg_data[63:0];
        REG_TRANS: translation_xyz <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // Input beat is held for the whole sequence
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      v_x     <= vert_x;
      v_y     <= vert_y;
      v_z     <= vert_z;
      v_final <= final_vertex;
    end
  end

  vtbb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .issue    (issue),
    .commit   (commit)
  );

  vtbb_mac #(
    .COORD_WIDTH     (COORD_WIDTH),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .QUAT_FRAC_BITS  (QUAT_FRAC_BITS)
  ) u_mac (
    .clk             (clk),
    .rst             (rst),
    .v_x             (v_x),
    .v_y             (v_y),
    .v_z             (v_z),
    .scale_xyz       (scale_xyz),
    .rotation_quat   (rotation_quat),
    .translation_xyz (translation_xyz),
    .issue           (issue),
    .fin             (fin),
    .fin_value       (fin_value)
  );

  vtbb_box #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_box (
    .clk          (clk),
    .rst          (rst),
    .fin          (fin),
    .fin_value    (fin_value),
    .commit       (commit),
    .commit_final (v_final),
    .vtx_x        (vtx_x),
    .vtx_y        (vtx_y),
    .vtx_z        (vtx_z),
    .run_min_x    (run_min_x),
    .run_min_y    (run_min_y),
    .run_min_z    (run_min_z),
    .run_max_x    (run_max_x),
    .run_max_y    (run_max_y),
    .run_max_z    (run_max_z)
  );

  // Output register: loaded on commit, held until the beat is taken
  always_ff @(posedge clk) begin
    if (commit) begin
      out_x     <= vtx_x;
      out_y     <= vtx_y;
      out_z     <= vtx_z;
      box_min_x <= run_min_x;
      box_min_y <= run_min_y;
      box_min_z <= run_min_z;
      box_max_x <= run_max_x;
      box_max_y <= run_max_y;
      box_max_z <= run_max_z;
      box_done  <= v_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_IMP(a_commit_free, clk, rst, commit, !out_valid || out_ready, "result overwrote a pending beat")
  `ASSERT_IMP(a_idle_no_mac, clk, rst, in_ready, !fin.valid, "box update while idle")

endmodule
